// ----- design/dual_channel_pid_position_control_macros.svh -----
`ifndef DUAL_CHANNEL_PID_POSITION_CONTROL_MACROS_SVH
`define DUAL_CHANNEL_PID_POSITION_CONTROL_MACROS_SVH

// same-cycle implication, disabled in reset
`define DCP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dcp_pkg.sv -----
package dcp_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned ErrW       = SampleBits + 1;
  localparam int unsigned DiffW      = SampleBits + 2;
  localparam int unsigned IntegW     = 24;
  localparam int unsigned GainW      = 28;
  localparam int unsigned WinW       = 12;
  localparam int unsigned ClampW     = 23;
  localparam int unsigned FracBits   = 24;
  localparam int unsigned ProdPW     = GainW + 1 + ErrW;
  localparam int unsigned ProdIW     = GainW + 1 + IntegW;
  localparam int unsigned ProdDW     = GainW + 1 + DiffW;
  localparam int unsigned SumW       = ProdIW + 2;
  localparam int unsigned OutW       = 8;
  localparam int          OutLimit   = 127;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 32;

  localparam logic [GainW-1:0]  KpReset    = GainW'(335544);
  localparam logic [GainW-1:0]  KiReset    = GainW'(168);
  localparam logic [GainW-1:0]  KdReset    = GainW'(167772);
  localparam logic [WinW-1:0]   WinReset   = WinW'(200);
  localparam logic [ClampW-1:0] ClampReset = ClampW'(5000000);

  typedef enum logic [2:0] {
    REG_GAIN_P = 3'd0,
    REG_GAIN_I = 3'd1,
    REG_GAIN_D = 3'd2,
    REG_WINDOW = 3'd3,
    REG_CLAMP  = 3'd4
  } dcp_reg_e;

  typedef struct packed {
    logic [SampleBits-1:0] sample_left;
    logic [SampleBits-1:0] sample_right;
    logic [SampleBits-1:0] target_left;
    logic [SampleBits-1:0] target_right;
  } dcp_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] drive_motor_one;
    logic signed [OutW-1:0] drive_motor_two;
  } dcp_out_t;

  typedef struct packed {
    logic [GainW-1:0]  gain_proportional;
    logic [GainW-1:0]  gain_integral;
    logic [GainW-1:0]  gain_derivative;
    logic [WinW-1:0]   integral_window;
    logic [ClampW-1:0] integral_clamp;
  } dcp_cfg_t;

  typedef struct packed {
    logic accept;
    logic en1;
    logic en2;
    logic en3;
  } dcp_lane_ctl_t;

endpackage

// ----- design/dcp_cfg.sv -----
module dcp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcp_pkg::AddrW-1:0]    paddr,
  input  logic [dcp_pkg::DataW-1:0]    pwdata,
  output logic [dcp_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output dcp_pkg::dcp_cfg_t            cfg_o
);

  dcp_pkg::dcp_cfg_t cfg_q;
  dcp_pkg::dcp_reg_e idx;
  logic              wr;

  assign idx    = dcp_pkg::dcp_reg_e'(paddr[dcp_pkg::AddrW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_proportional <= dcp_pkg::KpReset;
      cfg_q.gain_integral     <= dcp_pkg::KiReset;
      cfg_q.gain_derivative   <= dcp_pkg::KdReset;
      cfg_q.integral_window   <= dcp_pkg::WinReset;
      cfg_q.integral_clamp    <= dcp_pkg::ClampReset;
    end else if (wr) begin
      unique case (idx)
        dcp_pkg::REG_GAIN_P: cfg_q.gain_proportional <= pwdata[dcp_pkg::GainW-1:0];
        dcp_pkg::REG_GAIN_I: cfg_q.gain_integral     <= pwdata[dcp_pkg::GainW-1:0];
        dcp_pkg::REG_GAIN_D: cfg_q.gain_derivative   <= pwdata[dcp_pkg::GainW-1:0];
        dcp_pkg::REG_WINDOW: cfg_q.integral_window   <= pwdata[dcp_pkg::WinW-1:0];
        dcp_pkg::REG_CLAMP:  cfg_q.integral_clamp    <= pwdata[dcp_pkg::ClampW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dcp_pkg::REG_GAIN_P: prdata = dcp_pkg::DataW'(cfg_q.gain_proportional);
      dcp_pkg::REG_GAIN_I: prdata = dcp_pkg::DataW'(cfg_q.gain_integral);
      dcp_pkg::REG_GAIN_D: prdata = dcp_pkg::DataW'(cfg_q.gain_derivative);
      dcp_pkg::REG_WINDOW: prdata = dcp_pkg::DataW'(cfg_q.integral_window);
      dcp_pkg::REG_CLAMP:  prdata = dcp_pkg::DataW'(cfg_q.integral_clamp);
      default:             prdata = '0;
    endcase
  end

endmodule

// ----- design/dcp_lane.sv -----
module dcp_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dcp_pkg::dcp_lane_ctl_t                ctl_i,
  input  dcp_pkg::dcp_cfg_t                     cfg_i,
  input  logic [dcp_pkg::SampleBits-1:0]        target_i,
  input  logic [dcp_pkg::SampleBits-1:0]        sample_i,
  output logic signed [dcp_pkg::SumW-1:0]       sum_o
);

  localparam int unsigned ErrW   = dcp_pkg::ErrW;
  localparam int unsigned IntegW = dcp_pkg::IntegW;
  localparam int unsigned DiffW  = dcp_pkg::DiffW;
  localparam int unsigned SumW   = dcp_pkg::SumW;

  // loop state
  logic signed [ErrW-1:0]   prev_q;
  logic signed [IntegW-1:0] integ_q;

  logic signed [ErrW-1:0]   err_d;
  logic        [ErrW-1:0]   mag;
  logic                     win_hit;
  logic signed [IntegW:0]   acc;
  logic signed [IntegW:0]   lim;
  logic signed [IntegW:0]   acc_sat;
  logic signed [IntegW-1:0] integ_d;
  logic signed [DiffW-1:0]  diff_d;

  // stage 1: operands
  logic signed [ErrW-1:0]   err_q;
  logic signed [IntegW-1:0] integ_s1_q;
  logic signed [DiffW-1:0]  diff_q;
  // stage 2: products
  logic signed [dcp_pkg::ProdPW-1:0] prod_p_q;
  logic signed [dcp_pkg::ProdIW-1:0] prod_i_q;
  logic signed [dcp_pkg::ProdDW-1:0] prod_d_q;
  // stage 3: sum
  logic signed [SumW-1:0]   sum_q;

  always_comb begin
    err_d   = $signed({1'b0, target_i}) - $signed({1'b0, sample_i});
    mag     = err_d[ErrW-1] ? unsigned'(-err_d) : unsigned'(err_d);
    win_hit = (err_d != '0) &&
              (mag < {{(ErrW-dcp_pkg::WinW){1'b0}}, cfg_i.integral_window});
    acc     = $signed({integ_q[IntegW-1], integ_q}) +
              $signed({{(IntegW+1-ErrW){err_d[ErrW-1]}}, err_d});
    lim     = $signed({{(IntegW+1-dcp_pkg::ClampW){1'b0}}, cfg_i.integral_clamp});
    if (acc > lim) begin
      acc_sat = lim;
    end else if (acc < -lim) begin
      acc_sat = -lim;
    end else begin
      acc_sat = acc;
    end
    integ_d = win_hit ? acc_sat[IntegW-1:0] : integ_q;
    diff_d  = $signed({err_d[ErrW-1], err_d}) - $signed({prev_q[ErrW-1], prev_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else if (ctl_i.accept) begin
      prev_q  <= err_d;
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      err_q      <= err_d;
      integ_s1_q <= integ_d;
      diff_q     <= diff_d;
    end
    if (ctl_i.en2) begin
      prod_p_q <= $signed({1'b0, cfg_i.gain_proportional}) * err_q;
      prod_i_q <= $signed({1'b0, cfg_i.gain_integral}) * integ_s1_q;
      prod_d_q <= $signed({1'b0, cfg_i.gain_derivative}) * diff_q;
    end
    if (ctl_i.en3) begin
      sum_q <= SumW'(prod_p_q) + SumW'(prod_i_q) + SumW'(prod_d_q);
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- design/dcp_merge.sv -----
module dcp_merge (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [dcp_pkg::SumW-1:0]  sum_right_i,
  input  logic signed [dcp_pkg::SumW-1:0]  sum_left_i,
  output logic                             take_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output dcp_pkg::dcp_out_t                out_data_o
);

  localparam int unsigned SumW = dcp_pkg::SumW;

  // Q.24 to integer, truncated toward zero, then clipped to +-127
  function automatic logic signed [dcp_pkg::OutW-1:0] to_drive(
    input logic signed [SumW-1:0] v
  );
    logic        [SumW-1:0] bias;
    logic signed [SumW-1:0] t;
    logic signed [SumW-1:0] sh;
    logic signed [dcp_pkg::OutW-1:0] r;
    bias = v[SumW-1] ? {{(SumW-dcp_pkg::FracBits){1'b0}}, {dcp_pkg::FracBits{1'b1}}} : '0;
    t    = v + $signed(bias);
    sh   = t >>> dcp_pkg::FracBits;
    if (sh > SumW'(dcp_pkg::OutLimit)) begin
      r = dcp_pkg::OutW'(dcp_pkg::OutLimit);
    end else if (sh < SumW'(-dcp_pkg::OutLimit)) begin
      r = dcp_pkg::OutW'(-dcp_pkg::OutLimit);
    end else begin
      r = sh[dcp_pkg::OutW-1:0];
    end
    return r;
  endfunction

  logic              valid_q;
  dcp_pkg::dcp_out_t data_q;

  assign take_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      data_q.drive_motor_one <= to_drive(sum_right_i);
      data_q.drive_motor_two <= -to_drive(sum_left_i);
    end
  end

endmodule

// ----- design/dual_channel_pid_position_control.sv -----
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------
// input     | in_valid_i / in_ready_o    | in_data_i  (dcp_in_t, 4 x 12 bit)
// output    | out_valid_o / out_ready_i  | out_data_o (dcp_out_t, 2 x s8)
// config    | psel/penable/pwrite/pready | paddr[4:0], pwdata, prdata
//
// One item per cycle while the output is not stalled.
// Error, windowed integral and loop state update in the accept cycle, then
// product, sum, and divide/clip into the output register, one lane per arm.
// Stages advance independently, so bubbles close up behind a stalled result.
// Reset clears loop state and valids and sets config registers to their defaults.

`include "dual_channel_pid_position_control_macros.svh"

module dual_channel_pid_position_control (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dcp_pkg::dcp_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dcp_pkg::dcp_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcp_pkg::AddrW-1:0]     paddr,
  input  logic [dcp_pkg::DataW-1:0]     pwdata,
  output logic [dcp_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  dcp_pkg::dcp_cfg_t      cfg;
  dcp_pkg::dcp_lane_ctl_t ctl;
  logic                   v1_q, v2_q, v3_q;
  logic                   take;
  logic                   in_acc, out_acc;
  logic [2:0]             occ;
  logic signed [dcp_pkg::SumW-1:0] sum_left, sum_right;

  assign ctl.en3    = !v3_q || take;
  assign ctl.en2    = !v2_q || ctl.en3;
  assign ctl.en1    = !v1_q || ctl.en2;
  assign ctl.accept = in_valid_i && ctl.en1;
  assign in_ready_o = ctl.en1;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign occ        = {2'b00, v1_q} + {2'b00, v2_q} + {2'b00, v3_q} + {2'b00, out_valid_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ctl.en1) v1_q <= in_valid_i;
      if (ctl.en2) v2_q <= v1_q;
      if (ctl.en3) v3_q <= v2_q;
    end
  end

  dcp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dcp_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg),
    .target_i (in_data_i.target_left),
    .sample_i (in_data_i.sample_left),
    .sum_o    (sum_left)
  );

  dcp_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg),
    .target_i (in_data_i.target_right),
    .sample_i (in_data_i.sample_right),
    .sum_o    (sum_right)
  );

  dcp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v3_q),
    .sum_right_i (sum_right),
    .sum_left_i  (sum_left),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // input only blocks when every stage holds an item
  `DCP_ASSERT_IMPL(a_ready_full, clk_i, rst_ni, !in_ready_o, v1_q && v2_q && v3_q && out_valid_o, "input stalled with a free stage")
  // items in flight follow accepts and deliveries
  `DCP_ASSERT_IMPL(a_occupancy, clk_i, rst_ni, $past(rst_ni), occ == 3'($past(occ) + {2'b00, $past(in_acc)} - {2'b00, $past(out_acc)}), "item lost or invented")
  // results stay inside the symmetric range
  `DCP_ASSERT_IMPL(a_no_min, clk_i, rst_ni, out_valid_o, (out_data_o.drive_motor_one != -8'sd128) && (out_data_o.drive_motor_two != -8'sd128), "drive out of range")
  // a result only appears when the sum stage held one
  `DCP_ASSERT_IMPL(a_out_source, clk_i, rst_ni, $rose(out_valid_o), $past(v3_q), "result without item")

endmodule
